### rtl/column_logical_line_framer_unit_macros.svh
// Assertion macros shared by the checker of the line framer.
`ifndef COLUMN_LOGICAL_LINE_FRAMER_UNIT_MACROS_SVH
`define COLUMN_LOGICAL_LINE_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define CLF_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line framer check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define CLF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line framer check failed");

`endif

### rtl/clf_pkg.sv
// Shared types, constants and helper functions of the line framer.
`default_nettype none
package clf_pkg;

	localparam int unsigned LINE_BYTES_DEF = 512;
	// Widest byte count that any supported line size needs.
	localparam int unsigned SAT_W = 13;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] UTF_CONT_MASK = 8'hC0;
	localparam logic [7:0] UTF_CONT_TAG = 8'h80;
	localparam logic [6:0] NO_CONT_END_COL = 7'd80;

	localparam logic [1:0] EOL_NONE = 2'd0;
	localparam logic [1:0] EOL_LF = 2'd1;
	localparam logic [1:0] EOL_CR = 2'd2;
	localparam logic [1:0] EOL_CRLF = 2'd3;

	localparam logic [2:0] REG_BEGIN = 3'd0;
	localparam logic [2:0] REG_END = 3'd1;
	localparam logic [2:0] REG_CONT = 3'd2;
	localparam logic [2:0] REG_DBCS = 3'd3;
	localparam logic [2:0] REG_COPY = 3'd4;

	typedef struct packed {
		logic [5:0] begin_col;
		logic [6:0] end_col;
		logic [5:0] cont_col;
		logic       dbcs;
		logic       copy_eof;
	} cfg_t;

	typedef struct packed {
		logic       bank;
		logic [1:0] eol;
		logic       eof;
	} job_ctl_t;

	typedef enum logic [3:0] {
		B_IDLE, B_LEAD, B_LEADD, B_TRAIL, B_TRAILD, B_CCHK, B_CCHKD,
		B_DCMP, B_DCMPD, B_IND, B_INDD, B_EMIT
	} bstate_t;

	typedef enum logic [1:0] {WP_BEGIN, WP_CODE, WP_CONT, WP_STRIP} wphase_t;

	function automatic logic [8:0] sat9(input logic [SAT_W-1:0] v);
		sat9 = (v > SAT_W'(511)) ? 9'd511 : v[8:0];
	endfunction

	// Length of the UTF-8 sequence a lead byte opens; zero for a bad lead byte.
	function automatic logic [2:0] utf8_len(input logic [7:0] c);
		if (c < 8'h80) utf8_len = 3'd1;
		else if (c >= 8'hC0 && c < 8'hE0) utf8_len = 3'd2;
		else if (c >= 8'hE0 && c < 8'hF0) utf8_len = 3'd3;
		else if (c >= 8'hF0 && c < 8'hF8) utf8_len = 3'd4;
		else utf8_len = 3'd0;
	endfunction

endpackage
`default_nettype wire

### rtl/column_logical_line_framer_unit.sv
// Throughput: one byte a cycle while a line store bank is free and the job queue has
// room; a byte after a lone CR waits while that CR closes its line. A line summary
// follows its terminator once the scanner has walked the stored line, bound by the
// single read port of the line store.
// Reset: arst_n clears control state and loads the register defaults at once; the
// line store is not cleared and no clearing pass runs.
`default_nettype none
module column_logical_line_framer_unit import clf_pkg::*; #(
	parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_input,
	output logic             line_valid,
	input  wire logic        line_ready,
	output logic [1:0]       eol_kind,
	output logic [8:0]       line_length_bytes,
	output logic [8:0]       code_offset_bytes,
	output logic [8:0]       code_length_bytes,
	output logic [7:0]       code_offset_units,
	output logic [8:0]       cont_length_bytes,
	output logic [8:0]       tail_length_bytes,
	output logic             indent_error,
	output logic             shift_flag,
	output logic             segment_last,
	output logic             next_line_missing,
	output logic             encoding_error
);
	localparam int unsigned AW = $clog2(LINE_BYTES);
	localparam int unsigned LW = $clog2(LINE_BYTES + 1);

	cfg_t          cfg_q;
	logic          push, pop, full, empty, rel, rel_bank, wr_en, cfg_wr;
	job_ctl_t      push_ctl, head_ctl;
	logic [LW-1:0] push_len, head_len;
	logic [AW:0]   wr_addr;
	logic [7:0]    wr_data;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.begin_col <= 6'd1;
			cfg_q.end_col <= 7'd71;
			cfg_q.cont_col <= 6'd16;
			cfg_q.dbcs <= 1'b0;
			cfg_q.copy_eof <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_BEGIN: cfg_q.begin_col <= pwdata[5:0];
				REG_END: cfg_q.end_col <= pwdata[6:0];
				REG_CONT: cfg_q.cont_col <= pwdata[5:0];
				REG_DBCS: cfg_q.dbcs <= pwdata[0];
				REG_COPY: cfg_q.copy_eof <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_BEGIN: prdata = {26'd0, cfg_q.begin_col};
			REG_END: prdata = {25'd0, cfg_q.end_col};
			REG_CONT: prdata = {26'd0, cfg_q.cont_col};
			REG_DBCS: prdata = {31'd0, cfg_q.dbcs};
			REG_COPY: prdata = {31'd0, cfg_q.copy_eof};
			default: prdata = 32'd0;
		endcase
	end

	clf_front #(.LINE_BYTES(LINE_BYTES)) u_front (
		.clk, .arst_n, .byte_valid, .byte_ready, .data_byte, .end_of_input,
		.push, .push_ctl, .push_len, .fifo_full(full), .rel, .rel_bank,
		.wr_en, .wr_addr, .wr_data
	);

	clf_fifo #(.W(LW + $bits(job_ctl_t))) u_fifo (
		.clk, .arst_n, .push, .push_data({push_len, push_ctl}), .pop,
		.head({head_len, head_ctl}), .full, .empty
	);

	clf_back #(.LINE_BYTES(LINE_BYTES)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .job_valid(!empty), .job_ctl(head_ctl),
		.job_len(head_len), .pop, .wr_en, .wr_addr, .wr_data, .rel, .rel_bank,
		.line_valid, .line_ready, .eol_kind, .line_length_bytes, .code_offset_bytes,
		.code_length_bytes, .code_offset_units, .cont_length_bytes, .tail_length_bytes,
		.indent_error, .shift_flag, .segment_last, .next_line_missing, .encoding_error
	);
endmodule
`default_nettype wire

### rtl/clf_fifo.sv
// Two-entry job queue between the byte front end and the line scanner.
`default_nettype none
module clf_fifo #(
	parameter int unsigned W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic [W-1:0]      head,
	output logic              full,
	output logic              empty
);
	logic [W-1:0] ent_q [2];
	logic         wptr_q, rptr_q;
	logic [1:0]   cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head = ent_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wptr_q] <= push_data;
	end
endmodule
`default_nettype wire

### rtl/clf_front.sv
// Byte front end: stores line bytes, finds terminators and queues line jobs.
`default_nettype none
module clf_front import clf_pkg::*; #(
	parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        byte_valid,
	output logic                             byte_ready,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        end_of_input,
	output logic                             push,
	output job_ctl_t                         push_ctl,
	output logic [$clog2(LINE_BYTES+1)-1:0]  push_len,
	input  wire logic                        fifo_full,
	input  wire logic                        rel,
	input  wire logic                        rel_bank,
	output logic                             wr_en,
	output logic [$clog2(LINE_BYTES):0]      wr_addr,
	output logic [7:0]                       wr_data
);
	localparam int unsigned AW = $clog2(LINE_BYTES);
	localparam int unsigned LW = $clog2(LINE_BYTES + 1);

	logic [LW-1:0] count_q, cnt_inc;
	logic          pend_q, wbank_q;
	logic [1:0]    busy_q, busy_d;
	logic          is_lf, is_cr, plain, room, acc, flush_cr, free;

	assign is_lf = (data_byte == CH_LF);
	assign is_cr = (data_byte == CH_CR);
	assign plain = !is_lf && !is_cr;
	assign room = (count_q < LW'(LINE_BYTES));
	assign cnt_inc = room ? count_q + LW'(1) : count_q;
	assign free = !busy_q[wbank_q] && !fifo_full;

	// A CR followed by anything but LF closes its line before the byte is taken.
	assign flush_cr = byte_valid && pend_q && !is_lf && free;
	assign byte_ready = !(pend_q && !is_lf) && free;
	assign acc = byte_valid && byte_ready;

	assign wr_en = acc && plain && room;
	assign wr_addr = {wbank_q, count_q[AW-1:0]};
	assign wr_data = data_byte;

	always_comb begin
		push = flush_cr || (acc && (is_lf || end_of_input));
		push_ctl.bank = wbank_q;
		push_ctl.eof = flush_cr ? 1'b0 : end_of_input;
		if (flush_cr) push_ctl.eol = EOL_CR;
		else if (is_lf) push_ctl.eol = pend_q ? EOL_CRLF : EOL_LF;
		else if (is_cr) push_ctl.eol = EOL_CR;
		else push_ctl.eol = EOL_NONE;
		push_len = (acc && plain) ? cnt_inc : count_q;
		busy_d = busy_q;
		if (rel) busy_d[rel_bank] = 1'b0;
		if (push) busy_d[wbank_q] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q <= 1'b0;
			wbank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			busy_q <= busy_d;
			if (push) begin
				count_q <= '0;
				wbank_q <= ~wbank_q;
			end else if (acc && plain) begin
				count_q <= cnt_inc;
			end
			if (flush_cr) pend_q <= 1'b0;
			else if (acc) pend_q <= is_cr && !end_of_input;
		end
	end
endmodule
`default_nettype wire

### rtl/clf_back.sv
// Line scanner: walks one stored line by columns and builds its summary.
`default_nettype none
module clf_back import clf_pkg::*; #(
	parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire cfg_t                           cfg,
	input  wire logic                           job_valid,
	input  wire job_ctl_t                       job_ctl,
	input  wire logic [$clog2(LINE_BYTES+1)-1:0] job_len,
	output logic                                pop,
	input  wire logic                           wr_en,
	input  wire logic [$clog2(LINE_BYTES):0]    wr_addr,
	input  wire logic [7:0]                     wr_data,
	output logic                                rel,
	output logic                                rel_bank,
	output logic                                line_valid,
	input  wire logic                           line_ready,
	output logic [1:0]                          eol_kind,
	output logic [8:0]                          line_length_bytes,
	output logic [8:0]                          code_offset_bytes,
	output logic [8:0]                          code_length_bytes,
	output logic [7:0]                          code_offset_units,
	output logic [8:0]                          cont_length_bytes,
	output logic [8:0]                          tail_length_bytes,
	output logic                                indent_error,
	output logic                                shift_flag,
	output logic                                segment_last,
	output logic                                next_line_missing,
	output logic                                encoding_error
);
	localparam int unsigned AW = $clog2(LINE_BYTES);
	localparam int unsigned LW = $clog2(LINE_BYTES + 1);

	logic [7:0]    ram_q [2**(AW+1)];
	logic [7:0]    rd_q;
	logic [AW:0]   rd_addr;
	logic [LW-1:0] addr_l;

	bstate_t       state_q, state_d;
	wphase_t       phase_q;
	logic          in_cont_q, out_valid_q;
	logic          bank_q, eof_q, inf_q, err_q, indent_q, continued_q;
	logic [1:0]    eol_q, k_q, j_q;
	logic [2:0]    n_q, csz_q;
	logic [7:0]    cnt_q, u0_q;
	logic [LW-1:0] len_q, pos_q, lim_q, cs_q, ac_q, ce_q, ig_q, cont_s_q, tail_s_q;
	logic [7:0]    cb_q [4];

	logic [5:0]    b_eff;
	logic [7:0]    e1, code_chars, strip_n;
	logic          strip_inf, no_cont, count_units, walk_done, lead_bad, trail_bad;
	logic          dcmp_ok, mismatch, out_free, blank;
	logic [2:0]    lead_n;
	logic [1:0]    u_add;
	logic [LW-1:0] ce_now, span, chk, s_addr;
	logic          cont_on;
	logic [LW-1:0] tail_eff;
	bstate_t       after_st;

	function automatic logic [7:0] uadd(input logic [7:0] u, input logic [1:0] inc);
		logic [8:0] t;
		t = {1'b0, u} + {7'd0, inc};
		uadd = t[8] ? 8'd255 : t[7:0];
	endfunction

	// Column settings as the walk uses them.
	assign b_eff = (cfg.begin_col == 6'd0) ? 6'd1 : cfg.begin_col;
	assign e1 = {1'b0, cfg.end_col} + 8'd1;
	assign code_chars = (e1 >= {2'b0, b_eff}) ? e1 - {2'b0, b_eff} : 8'd0;
	assign strip_inf = (cfg.cont_col < b_eff);
	assign strip_n = {2'b0, cfg.cont_col - b_eff};
	assign no_cont = (cfg.end_col == NO_CONT_END_COL) || (cfg.cont_col == 6'd0);

	assign count_units = (phase_q == WP_BEGIN) || (phase_q == WP_STRIP);
	assign walk_done = (!inf_q && cnt_q == 8'd0) || (pos_q >= lim_q);
	assign lead_n = utf8_len(rd_q);
	assign lead_bad = (lead_n == 3'd0) || ((lim_q - pos_q) < LW'(lead_n));
	assign trail_bad = ((rd_q & UTF_CONT_MASK) != UTF_CONT_TAG);
	assign u_add = (n_q == 3'd4) ? 2'd2 : 2'd1;
	assign blank = (rd_q == CH_SPACE);

	// The code end is being set in the same cycle when the code walk finishes.
	assign ce_now = (state_q == B_LEAD && phase_q == WP_CODE) ? pos_q : ce_q;
	assign span = ce_now - cs_q;
	assign chk = (strip_inf || LW'(strip_n) >= span) ? span : LW'(strip_n);

	assign dcmp_ok = (ce_q >= cs_q + LW'(csz_q));
	assign s_addr = ce_q - LW'(csz_q) + LW'(j_q);
	assign mismatch = (rd_q != cb_q[j_q]);
	assign out_free = !out_valid_q || line_ready;
	assign after_st = in_cont_q ? B_IND : B_EMIT;

	assign cont_on = continued_q && !(eof_q && cfg.copy_eof);
	assign tail_eff = (eof_q && continued_q && cfg.copy_eof) ? cont_s_q : tail_s_q;

	always_ff @(posedge clk) begin
		if (wr_en) ram_q[wr_addr] <= wr_data;
		rd_q <= ram_q[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (job_valid) state_d = B_LEAD;
			B_LEAD: begin
				if (walk_done) begin
					unique case (phase_q)
						WP_BEGIN: state_d = B_LEAD;
						WP_CODE: state_d = (pos_q < len_q) ? B_CCHK : after_st;
						WP_CONT: state_d = cfg.dbcs ? B_DCMP : after_st;
						WP_STRIP: state_d = B_EMIT;
					endcase
				end else begin
					state_d = B_LEADD;
				end
			end
			B_LEADD: state_d = (lead_bad || lead_n == 3'd1) ? B_LEAD : B_TRAIL;
			B_TRAIL: state_d = B_TRAILD;
			B_TRAILD: state_d = (trail_bad || {1'b0, k_q} == n_q - 3'd1) ? B_LEAD : B_TRAIL;
			B_CCHK: state_d = B_CCHKD;
			B_CCHKD: state_d = (blank || no_cont) ? after_st : B_LEAD;
			B_DCMP: state_d = dcmp_ok ? B_DCMPD : after_st;
			B_DCMPD: state_d = mismatch ? after_st : B_DCMP;
			B_IND: state_d = (pos_q >= lim_q) ? B_LEAD : B_INDD;
			B_INDD: state_d = B_IND;
			B_EMIT: if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			B_TRAIL: addr_l = pos_q + LW'(k_q);
			B_DCMP: addr_l = s_addr;
			default: addr_l = pos_q;
		endcase
		rd_addr = {bank_q, addr_l[AW-1:0]};
		pop = (state_q == B_IDLE) && job_valid;
		rel = (state_q == B_EMIT) && out_free;
		rel_bank = bank_q;
		line_valid = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			in_cont_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rel) begin
				in_cont_q <= continued_q && !eof_q;
				out_valid_q <= 1'b1;
			end else if (line_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					bank_q <= job_ctl.bank;
					eol_q <= job_ctl.eol;
					eof_q <= job_ctl.eof;
					len_q <= job_len;
					lim_q <= job_len;
					tail_s_q <= job_len;
					pos_q <= '0;
					cnt_q <= {2'b0, b_eff} - 8'd1;
					inf_q <= 1'b0;
					phase_q <= WP_BEGIN;
					u0_q <= '0;
					err_q <= 1'b0;
					indent_q <= 1'b0;
					continued_q <= 1'b0;
				end
			end
			B_LEAD: begin
				if (walk_done) begin
					unique case (phase_q)
						WP_BEGIN: begin
							cs_q <= pos_q;
							cnt_q <= code_chars;
							phase_q <= WP_CODE;
						end
						WP_CODE: begin
							ac_q <= pos_q;
							ce_q <= pos_q;
							cont_s_q <= pos_q;
							if (pos_q >= len_q) begin
								pos_q <= cs_q;
								lim_q <= cs_q + chk;
							end
						end
						WP_CONT: begin
							ig_q <= pos_q;
							tail_s_q <= pos_q;
							continued_q <= 1'b1;
							csz_q <= 3'(pos_q - ac_q);
							j_q <= '0;
							if (!cfg.dbcs) begin
								pos_q <= cs_q;
								lim_q <= cs_q + chk;
							end
						end
						WP_STRIP: ;
					endcase
				end
			end
			B_LEADD: begin
				if (lead_bad || lead_n == 3'd1) begin
					if (lead_bad) err_q <= 1'b1;
					pos_q <= pos_q + LW'(1);
					if (count_units) u0_q <= uadd(u0_q, 2'd1);
					cnt_q <= cnt_q - 8'd1;
				end else begin
					n_q <= lead_n;
					k_q <= 2'd1;
				end
			end
			B_TRAIL: ;
			B_TRAILD: begin
				if (phase_q == WP_CONT) cb_q[k_q] <= rd_q;
				if (trail_bad) begin
					err_q <= 1'b1;
					pos_q <= pos_q + LW'(1);
					if (count_units) u0_q <= uadd(u0_q, 2'd1);
					cnt_q <= cnt_q - 8'd1;
				end else if ({1'b0, k_q} == n_q - 3'd1) begin
					pos_q <= pos_q + LW'(n_q);
					if (count_units) u0_q <= uadd(u0_q, u_add);
					cnt_q <= cnt_q - 8'd1;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			B_CCHK: ;
			B_CCHKD: begin
				cb_q[0] <= rd_q;
				if (blank || no_cont) begin
					tail_s_q <= ac_q;
					pos_q <= cs_q;
					lim_q <= cs_q + chk;
				end else begin
					cnt_q <= 8'd1;
					inf_q <= 1'b0;
					phase_q <= WP_CONT;
				end
			end
			B_DCMP: begin
				if (!dcmp_ok) begin
					pos_q <= cs_q;
					lim_q <= cs_q + chk;
				end
			end
			B_DCMPD: begin
				if (mismatch) begin
					// The run of repeated continuation characters starts here.
					cont_s_q <= ce_q;
					pos_q <= cs_q;
					lim_q <= cs_q + chk;
				end else if ({1'b0, j_q} == csz_q - 3'd1) begin
					ce_q <= ce_q - LW'(csz_q);
					j_q <= '0;
				end else begin
					j_q <= j_q + 2'd1;
				end
			end
			B_IND: begin
				if (pos_q >= lim_q) begin
					pos_q <= cs_q;
					cnt_q <= strip_n;
					inf_q <= strip_inf;
					lim_q <= ce_q;
					phase_q <= WP_STRIP;
				end
			end
			B_INDD: begin
				if (!blank) indent_q <= 1'b1;
				pos_q <= pos_q + LW'(1);
			end
			B_EMIT: begin
				if (out_free) begin
					eol_kind <= eol_q;
					line_length_bytes <= sat9(SAT_W'(len_q));
					code_offset_bytes <= sat9(SAT_W'(pos_q));
					code_length_bytes <= sat9(SAT_W'(ce_q - pos_q));
					code_offset_units <= u0_q;
					cont_length_bytes <= cont_on ? sat9(SAT_W'(ig_q - cont_s_q)) : 9'd0;
					tail_length_bytes <= sat9(SAT_W'(len_q - tail_eff));
					indent_error <= indent_q;
					shift_flag <= cfg.dbcs && continued_q && (ce_q != ac_q) &&
						(cb_q[0] == CH_LT || cb_q[0] == CH_GT);
					segment_last <= !continued_q || eof_q;
					next_line_missing <= eof_q && continued_q && !cfg.copy_eof;
					encoding_error <= err_q;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### rtl/clf_checker.sv
// Port-level checker of the line framer and its bind to the top level.
`default_nettype none
`include "column_logical_line_framer_unit_macros.svh"
module clf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       line_valid,
	input wire logic       line_ready,
	input wire logic [8:0] line_length_bytes,
	input wire logic [8:0] code_offset_bytes,
	input wire logic [8:0] code_length_bytes,
	input wire logic [8:0] cont_length_bytes,
	input wire logic [8:0] tail_length_bytes,
	input wire logic       segment_last,
	input wire logic       next_line_missing
);
	`CLF_ASSERT_NEXT(a_beat_held, line_valid && !line_ready, line_valid && $stable(line_length_bytes) && $stable(code_offset_bytes))
	// The code area, continuation and tail never overlap within an unsaturated line.
	`CLF_ASSERT_IMPLY(a_parts_fit, line_valid && line_length_bytes != 9'd511, 11'(code_offset_bytes) + 11'(code_length_bytes) + 11'(cont_length_bytes) + 11'(tail_length_bytes) <= 11'(line_length_bytes))
	`CLF_ASSERT_IMPLY(a_missing_last, line_valid && next_line_missing, segment_last && cont_length_bytes != 9'd0)
	`CLF_ASSERT_IMPLY(a_link_has_cont, line_valid && !segment_last, cont_length_bytes != 9'd0 && !next_line_missing)
endmodule

bind column_logical_line_framer_unit clf_checker u_clf_checker (.*);
`default_nettype wire

### tb/column_logical_line_framer_unit_tb.sv
// Self-checking testbench of the column logical line framer: random text in, line summaries checked.
`default_nettype none
module column_logical_line_framer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import clf_pkg::*;

	typedef struct packed {
		logic [1:0] eol;
		logic [8:0] len;
		logic [8:0] code_off;
		logic [8:0] code_len;
		logic [7:0] code_units;
		logic [8:0] cont_len;
		logic [8:0] tail_len;
		logic       indent;
		logic       shift;
		logic       last;
		logic       missing;
		logic       enc_err;
	} line_sum_t;

	class line_scoreboard;
		bit [7:0] store [512];
		int unsigned nbytes;
		bit cr_wait;
		bit cont_open;
		int unsigned bcol, ecol, ccol;
		bit dbcs, copy_eof;
		line_sum_t line_q [$];
		int errors;
		int unsigned walk_units;
		bit walk_err;

		function new();
			nbytes = 0;
			cr_wait = 0;
			cont_open = 0;
			bcol = 1;
			ecol = 71;
			ccol = 16;
			dbcs = 0;
			copy_eof = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_BEGIN: bcol = val & 32'h3F;
				REG_END: ecol = val & 32'h7F;
				REG_CONT: ccol = val & 32'h3F;
				REG_DBCS: dbcs = val[0];
				REG_COPY: copy_eof = val[0];
				default: ;
			endcase
		endfunction

		function int unsigned fit(int unsigned v, int unsigned max);
			return (v > max) ? max : v;
		endfunction

		// Steps over up to count characters; malformed UTF-8 counts as one byte.
		function int unsigned walk(int unsigned pos, int unsigned limit, int unsigned count,
				bit add_units);
			bit [7:0] c;
			int unsigned n, u, k;
			bit ok;
			while (count != 0 && pos < limit) begin
				c = store[pos];
				count--;
				u = 1;
				ok = 1;
				if (c < 8'h80) n = 1;
				else if (c >= 8'hC0 && c < 8'hE0) n = 2;
				else if (c >= 8'hE0 && c < 8'hF0) n = 3;
				else if (c >= 8'hF0 && c < 8'hF8) begin
					n = 4;
					u = 2;
				end else n = 0;
				if (n == 0 || limit - pos < n) ok = 0;
				else
					for (k = 1; k < n; k++)
						if ((store[pos + k] & 8'hC0) != 8'h80) ok = 0;
				if (!ok) begin
					walk_err = 1;
					n = 1;
					u = 1;
				end
				pos += n;
				if (add_units) walk_units += u;
			end
			return pos;
		endfunction

		function void close_line(logic [1:0] eol, bit eof);
			int unsigned len, b, cs, ac, code_end, cont_s, cont_e, tail_s, offs, ig;
			int unsigned code_chars, n, chk, csz, runs, i;
			int s;
			bit continued, shift, indent, missing, same;
			line_sum_t r;
			len = nbytes;
			b = (bcol != 0) ? bcol : 1;
			continued = 0;
			shift = 0;
			indent = 0;
			missing = 0;
			walk_units = 0;
			walk_err = 0;
			code_chars = (ecol + 1 >= b) ? ecol + 1 - b : 0;
			cs = walk(0, len, b - 1, 1);
			ac = walk(cs, len, code_chars, 0);
			code_end = ac;
			cont_s = ac;
			cont_e = ac;
			tail_s = len;
			if (ac < len) begin
				if (store[ac] == CH_SPACE || ecol == 80 || ccol == 0) begin
					tail_s = ac;
				end else begin
					ig = walk(ac, len, 1, 0);
					continued = 1;
					cont_e = ig;
					tail_s = ig;
					if (dbcs) begin
						csz = ig - ac;
						s = int'(ac) - int'(csz);
						runs = 1;
						// Walk back over repeats of the continuation character.
						while (s >= int'(cs)) begin
							same = 1;
							for (i = 0; i < csz; i++)
								if (store[s + i] != store[ac + i]) same = 0;
							if (!same) begin
								cont_s = s + csz;
								break;
							end
							runs++;
							s -= csz;
						end
						if (runs > 1) begin
							code_end = ac - (runs - 1) * csz;
							shift = (store[cont_s] == CH_LT || store[cont_s] == CH_GT);
						end
					end
				end
			end
			offs = cs;
			if (cont_open) begin
				n = (ccol >= b) ? ccol - b : 32'hFFFF_FFFF;
				chk = (n < code_end - cs) ? n : code_end - cs;
				for (i = 0; i < chk; i++)
					if (store[cs + i] != CH_SPACE) indent = 1;
				offs = walk(cs, code_end, n, 1);
			end
			if (eof && continued) begin
				if (copy_eof) begin
					tail_s = cont_s;
					cont_e = cont_s;
				end else missing = 1;
			end
			r.eol = eol;
			r.len = 9'(fit(len, 511));
			r.code_off = 9'(fit(offs, 511));
			r.code_len = 9'(fit(code_end - offs, 511));
			r.code_units = 8'(fit(walk_units, 255));
			r.cont_len = 9'(fit(cont_e - cont_s, 511));
			r.tail_len = 9'(fit(len - tail_s, 511));
			r.indent = indent;
			r.shift = shift;
			r.last = !continued || eof;
			r.missing = missing;
			r.enc_err = walk_err;
			line_q.push_back(r);
			cont_open = continued && !eof;
			nbytes = 0;
		endfunction

		// Notes one accepted input beat and queues the line summaries it causes.
		function void take_byte(logic [7:0] d, bit eof);
			if (cr_wait) begin
				cr_wait = 0;
				if (d == CH_LF) begin
					close_line(EOL_CRLF, eof);
					if (eof) cont_open = 0;
					return;
				end
				close_line(EOL_CR, 0);
			end
			if (d == CH_LF) close_line(EOL_LF, eof);
			else if (d == CH_CR) begin
				if (eof) close_line(EOL_CR, 1);
				else cr_wait = 1;
			end else begin
				if (nbytes < 512) begin
					store[nbytes] = d;
					nbytes++;
				end
				if (eof) close_line(EOL_NONE, 1);
			end
			if (eof) begin
				cont_open = 0;
				cr_wait = 0;
				nbytes = 0;
			end
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task cmp(string name, int unsigned got, int unsigned want);
			if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
		endtask

		task check_line(line_sum_t got);
			line_sum_t w;
			if (line_q.size() == 0) begin
				report("line summary with none expected");
				return;
			end
			w = line_q.pop_front();
			cmp("eol_kind", got.eol, w.eol);
			cmp("line_length_bytes", got.len, w.len);
			cmp("code_offset_bytes", got.code_off, w.code_off);
			cmp("code_length_bytes", got.code_len, w.code_len);
			cmp("code_offset_units", got.code_units, w.code_units);
			cmp("cont_length_bytes", got.cont_len, w.cont_len);
			cmp("tail_length_bytes", got.tail_len, w.tail_len);
			cmp("indent_error", got.indent, w.indent);
			cmp("shift_flag", got.shift, w.shift);
			cmp("segment_last", got.last, w.last);
			cmp("next_line_missing", got.missing, w.missing);
			cmp("encoding_error", got.enc_err, w.enc_err);
		endtask
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic byte_valid, byte_ready, end_of_input;
	logic [7:0] data_byte;
	logic line_valid, line_ready;
	logic [1:0] eol_kind;
	logic [8:0] line_length_bytes, code_offset_bytes, code_length_bytes;
	logic [7:0] code_offset_units;
	logic [8:0] cont_length_bytes, tail_length_bytes;
	logic indent_error, shift_flag, segment_last, next_line_missing, encoding_error;

	line_scoreboard sb;
	bit no_idle;
	logic [7:0] text_q [$];
	bit eof_q [$];

	column_logical_line_framer_unit u_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && line_valid && line_ready)
			sb.check_line({eol_kind, line_length_bytes, code_offset_bytes, code_length_bytes,
				code_offset_units, cont_length_bytes, tail_length_bytes, indent_error,
				shift_flag, segment_last, next_line_missing, encoding_error});

	// Receiver: random stall before taking each line summary.
	initial begin
		int n;
		line_ready = 0;
		@(posedge arst_n);
		forever begin
			n = no_idle ? 0 : $urandom_range(17);
			repeat (n) begin
				@(negedge clk);
				line_ready <= 0;
			end
			@(negedge clk);
			line_ready <= 1;
			do @(posedge clk); while (!line_valid);
		end
	end

	task apb_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
	endtask

	task send_byte(logic [7:0] d, bit eof);
		int gap;
		gap = no_idle ? 0 : $urandom_range(17);
		repeat (gap) begin
			byte_valid <= 0;
			@(negedge clk);
		end
		byte_valid <= 1;
		data_byte <= d;
		end_of_input <= eof;
		do @(posedge clk); while (!byte_ready);
		sb.take_byte(d, eof);
		@(negedge clk);
	endtask

	task send_text();
		foreach (text_q[i]) send_byte(text_q[i], eof_q[i]);
		byte_valid <= 0;
		text_q.delete();
		eof_q.delete();
	endtask

	task drain();
		while (sb.line_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	task put(logic [7:0] d);
		text_q.push_back(d);
		eof_q.push_back(0);
	endtask

	task put_char();
		int r;
		r = $urandom_range(99);
		if (r < 70) put(8'($urandom_range(8'h21, 8'h7E)));
		else if (r < 80) put(CH_SPACE);
		else if (r < 86) begin
			put(8'h C0 | 8'($urandom_range(31)));
			put(8'h80 | 8'($urandom_range(63)));
		end else if (r < 91) begin
			put(8'hE0 | 8'($urandom_range(15)));
			put(8'h80 | 8'($urandom_range(63)));
			put(8'h80 | 8'($urandom_range(63)));
		end else if (r < 94) begin
			put(8'hF0 | 8'($urandom_range(7)));
			repeat (3) put(8'h80 | 8'($urandom_range(63)));
		end else put(8'($urandom_range(255)));
	endtask

	task put_term();
		case ($urandom_range(2))
			0: put(CH_LF);
			1: put(CH_CR);
			default: begin
				put(CH_CR);
				put(CH_LF);
			end
		endcase
	endtask

	// A card: optional indent of mostly blanks, code up to the end column, continuation and tail.
	task put_card();
		int cols, runs, k, kind;
		cols = sb.ecol;
		if ($urandom_range(1)) begin
			for (k = 1; k < sb.ccol && cols > 0; k++) begin
				put(($urandom_range(15) == 0) ? 8'h41 : CH_SPACE);
				cols--;
			end
		end
		runs = (sb.dbcs || $urandom_range(4) == 0) ? $urandom_range(3) : 0;
		kind = $urandom_range(5);
		if (cols > runs && $urandom_range(9) != 0) cols -= runs;
		else runs = 0;
		repeat (cols) put_char();
		repeat (runs + 1) begin
			case (kind)
				0: put(CH_SPACE);
				1: put(CH_LT);
				2: put(CH_GT);
				3: begin
					put(8'hC3);
					put(8'hA9);
				end
				default: put(8'h58);
			endcase
		end
		repeat ($urandom_range(10)) put(8'($urandom_range(8'h21, 8'h7E)));
	endtask

	task build_text(int bytes, bit long_line);
		int i;
		if (long_line) begin
			repeat ($urandom_range(515, 560)) put(8'($urandom_range(8'h20, 8'h7E)));
			put_term();
		end
		while (text_q.size() < bytes) begin
			if ($urandom_range(9) < 7) put_card();
			else repeat ($urandom_range(40)) put(8'($urandom_range(255)));
			put_term();
			if ($urandom_range(29) == 0) eof_q[eof_q.size() - 1] = 1;
		end
		if ($urandom_range(1)) put_char();
		eof_q[eof_q.size() - 1] = 1;
	endtask

	task set_all(int b, int e, int c, int d, int cp);
		apb_write(REG_BEGIN, b);
		apb_write(REG_END, e);
		apb_write(REG_CONT, c);
		apb_write(REG_DBCS, d);
		apb_write(REG_COPY, cp);
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		byte_valid = 0;
		data_byte = 0;
		end_of_input = 0;
		no_idle = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed text under the reset settings: terminators, CR pairs, bad and wide UTF-8.
		put(8'h41); put(CH_LF);
		put(CH_LF);
		put(CH_CR); put(8'h62); put(CH_LF);
		put(8'h63); put(CH_CR); put(CH_LF);
		put(8'hFF); put(8'h80); put(8'hC3); put(CH_LF);
		put(8'hF0); put(8'h9F); put(8'h98); put(8'h80); put(CH_LF);
		put(CH_SPACE); put(8'hE2); put(8'h82); put(CH_CR);
		put(8'h7F); put(CH_CR);
		eof_q[eof_q.size() - 1] = 1;
		send_text();

		for (int p = 1; p <= 8; p++) begin
			drain();
			no_idle = (p % 3 == 2);
			case (p)
				1: set_all(1, 71, 16, 0, 0);
				2: set_all(40, 80, 40, 1, 1);
				3: set_all(1, 41, 40, 1, 0);
				4: set_all(10, 60, 5, 1, 1);
				5: set_all(0, 50, 2, 0, 1);
				6: set_all(20, 72, 30, 1, 0);
				7: set_all(40, 41, 0, 1, 1);
				default: set_all($urandom_range(1, 40), $urandom_range(41, 79),
					$urandom_range(1, 40), $urandom_range(1), $urandom_range(1));
			endcase
			build_text(60, p == 3 || p == 6);
			send_text();
		end
		drain();
		repeat (1200) @(posedge clk);
		if (sb.errors == 0 && sb.line_q.size() == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
